### rtl/kss_pkg.sv
//------------------------------------------------------------------------------
// Keyed semaphore set engine package
// Shared types and constants for the semaphore set engine.
//------------------------------------------------------------------------------
`default_nettype none
package kss_pkg;
	localparam int NumSets    = 16;
	localparam int SemsPerSet = 16;
	localparam int ValueBits  = 15;
	localparam int StageDepth = 16;
	localparam int SetW       = $clog2(NumSets);
	localparam int SemW       = $clog2(SemsPerSet);
	localparam int StgW       = $clog2(StageDepth);

	typedef enum logic [2:0] {
		CMD_OPEN   = 3'd0,
		CMD_SEMOP  = 3'd1,
		CMD_SETVAL = 3'd2,
		CMD_GETVAL = 3'd3,
		CMD_REMOVE = 3'd4
	} cmd_e;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_BADARG = 3'd1,
		ST_NOTFND = 3'd2,
		ST_FULL   = 3'd3,
		ST_NOWAIT = 3'd4,
		ST_BLOCK  = 3'd5,
		ST_OVF    = 3'd6
	} status_e;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [3:0]  set_id;
		logic [30:0] set_key;
		logic [4:0]  sem_count;
		logic        create;
		logic [3:0]  sem_index;
		logic signed [15:0] op_delta;
		logic        nowait;
		logic [14:0] new_value;
		logic        last;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  result_set;
		logic [14:0] read_value;
		logic        wake;
	} rsp_t;
endpackage
`default_nettype wire

### rtl/keyed_semaphore_set_engine.sv
//------------------------------------------------------------------------------
// Keyed semaphore set engine
// An open scans the sets for its key when that key is nonzero, then for a free
// set, and clears the new set's values. A closing semop runs an index pass, a
// check pass that reads and writes back each staged op, and a commit pass. A
// non-final semop element gives no response. One request at a time; the next
// is taken in the cycle after the response is accepted. Reset clears the live
// flags and staging at once.
//------------------------------------------------------------------------------
`default_nettype none
module keyed_semaphore_set_engine import kss_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire req_t in_data,
	output logic      out_valid,
	input  wire logic out_stall,
	output rsp_t      out_data
);
	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_SCANK = 9'b000000010,
		S_SCANF = 9'b000000100,
		S_CLEAR = 9'b000001000,
		S_IDXCK = 9'b000010000,
		S_CHKRD = 9'b000100000,
		S_CHKWB = 9'b001000000,
		S_COMMIT= 9'b010000000,
		S_SGRD  = 9'b100000000
	} state_t;

	state_t state_q;
	req_t   req_q;
	logic   ovalid_q;
	rsp_t   odata_q;

	logic [NumSets-1:0] live_q;
	logic [30:0] key_mem [NumSets];
	logic [4:0]  size_mem [NumSets];
	logic [ValueBits-1:0] val_mem [NumSets*SemsPerSet];
	logic [ValueBits-1:0] rd_q;

	logic [SemW-1:0]       st_idx [StageDepth];
	logic signed [15:0]    st_dlt [StageDepth];
	logic                  st_nw  [StageDepth];
	logic [StgW:0]  st_cnt_q;
	logic [SetW-1:0] st_set_q;
	logic           st_bad_q;

	// Scratch copy of the staged set's values used during the check pass.
	logic [ValueBits-1:0] work_q [SemsPerSet];
	logic [SemsPerSet-1:0] wvld_q;

	logic [StgW:0]  k_q;
	logic [SetW:0]  i_q;
	logic           blk_q, nwf_q, ovf_q;

	logic mem_we;
	logic [SetW+SemW-1:0] mem_wa, mem_ra;
	logic [ValueBits-1:0] mem_wd;

	assign in_stall  = (state_q != S_IDLE) || ovalid_q;
	assign out_valid = ovalid_q;
	assign out_data  = odata_q;

	always_ff @(posedge clk) begin
		if (mem_we) val_mem[mem_wa] <= mem_wd;
		rd_q <= val_mem[mem_ra];
	end

	logic [SetW-1:0] ki;
	logic [SemW-1:0] kx;
	logic signed [ValueBits+1:0] vsum;
	logic [ValueBits-1:0] vcur;
	logic [StgW-1:0] kk;
	assign kk = k_q[StgW-1:0];
	assign kx = st_idx[kk];
	assign vcur = wvld_q[kx] ? work_q[kx] : rd_q;
	assign vsum = $signed({2'b00, vcur}) + (ValueBits+2)'(st_dlt[kk]);
	assign ki = i_q[SetW-1:0];

	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		mem_ra = {st_set_q, kx};
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = {req_q.set_id, k_q[SemW-1:0]};
			end
			S_COMMIT: begin
				mem_we = wvld_q[k_q[SemW-1:0]];
				mem_wa = {st_set_q, k_q[SemW-1:0]};
				mem_wd = work_q[k_q[SemW-1:0]];
			end
			S_IDLE: begin
				if (in_valid && !in_stall && in_data.cmd == CMD_SETVAL &&
						live_q[in_data.set_id] &&
						{1'b0, in_data.sem_index} < size_mem[in_data.set_id]) begin
					mem_we = 1'b1;
					mem_wa = {in_data.set_id, in_data.sem_index};
					mem_wd = in_data.new_value;
				end
				mem_ra = {in_data.set_id, in_data.sem_index};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && !in_stall &&
				in_data.cmd == CMD_SEMOP && !st_cnt_q[StgW]) begin
			st_idx[st_cnt_q[StgW-1:0]] <= in_data.sem_index;
			st_dlt[st_cnt_q[StgW-1:0]] <= in_data.op_delta;
			st_nw[st_cnt_q[StgW-1:0]]  <= in_data.nowait;
		end
		if (state_q == S_SCANF && !live_q[ki]) begin
			key_mem[ki]  <= req_q.set_key;
			size_mem[ki] <= req_q.sem_count;
			req_q.set_id <= ki;
		end
		if (state_q == S_CHKWB) begin
			if (!((st_dlt[kk] < 0 && vsum < 0) || (st_dlt[kk] == 0 && vcur != '0)) &&
					vsum <= $signed({2'b00, {ValueBits{1'b1}}})) begin
				work_q[kx] <= vsum[ValueBits-1:0];
			end
		end
		if (state_q == S_IDXCK && k_q == st_cnt_q) begin
			for (int j = 0; j < SemsPerSet; j++) work_q[j] <= '0;
		end
		if (state_q == S_IDLE && in_valid && !in_stall) req_q <= in_data;
	end

	function automatic rsp_t mk(logic [2:0] s, logic [3:0] r, logic [14:0] v, logic w);
		rsp_t o;
		o.status = s; o.result_set = r; o.read_value = v; o.wake = w;
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
			live_q   <= '0;
			st_cnt_q <= '0;
			st_set_q <= '0;
			st_bad_q <= 1'b0;
			k_q      <= '0;
			i_q      <= '0;
			blk_q    <= 1'b0;
			nwf_q    <= 1'b0;
			ovf_q    <= 1'b0;
			wvld_q   <= '0;
			odata_q  <= '0;
		end else begin
			if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						k_q <= '0;
						i_q <= '0;
						unique case (in_data.cmd)
							CMD_OPEN: begin
								if (in_data.sem_count == '0 || in_data.sem_count > 5'(SemsPerSet)) begin
									ovalid_q <= 1'b1; odata_q <= mk(ST_BADARG, '0, '0, 1'b0);
								end else if (in_data.set_key != '0) state_q <= S_SCANK;
								else state_q <= S_SCANF;
							end
							CMD_SEMOP: begin
								if (st_cnt_q == '0) begin
									st_set_q <= in_data.set_id; st_bad_q <= 1'b0;
								end else if (st_set_q != in_data.set_id || st_cnt_q[StgW]) begin
									st_bad_q <= 1'b1;
								end
								if (!st_cnt_q[StgW]) st_cnt_q <= st_cnt_q + 1'b1;
								if (in_data.last) state_q <= S_IDXCK;
							end
							CMD_SETVAL, CMD_GETVAL: begin
								if (!live_q[in_data.set_id]) begin
									ovalid_q <= 1'b1; odata_q <= mk(ST_NOTFND, '0, '0, 1'b0);
								end else if ({1'b0, in_data.sem_index} >= size_mem[in_data.set_id]) begin
									ovalid_q <= 1'b1; odata_q <= mk(ST_BADARG, '0, '0, 1'b0);
								end else if (in_data.cmd == CMD_SETVAL) begin
									ovalid_q <= 1'b1; odata_q <= mk(ST_OK, '0, '0, 1'b1);
								end else state_q <= S_SGRD;
							end
							CMD_REMOVE: begin
								ovalid_q <= 1'b1;
								if (!live_q[in_data.set_id]) odata_q <= mk(ST_NOTFND, '0, '0, 1'b0);
								else begin
									live_q[in_data.set_id] <= 1'b0;
									odata_q <= mk(ST_OK, '0, '0, 1'b1);
								end
							end
							default: begin
								ovalid_q <= 1'b1; odata_q <= mk(ST_BADARG, '0, '0, 1'b0);
							end
						endcase
					end
				end
				S_SGRD: begin
					ovalid_q <= 1'b1; odata_q <= mk(ST_OK, '0, rd_q, 1'b0);
					state_q <= S_IDLE;
				end
				S_SCANK: begin
					if (live_q[ki] && key_mem[ki] == req_q.set_key) begin
						ovalid_q <= 1'b1; odata_q <= mk(ST_OK, ki, '0, 1'b0);
						state_q <= S_IDLE;
					end else if (i_q == (SetW+1)'(NumSets-1)) begin
						i_q <= '0;
						if (!req_q.create) begin
							ovalid_q <= 1'b1; odata_q <= mk(ST_NOTFND, '0, '0, 1'b0);
							state_q <= S_IDLE;
						end else state_q <= S_SCANF;
					end else i_q <= i_q + 1'b1;
				end
				S_SCANF: begin
					if (!live_q[ki]) begin
						live_q[ki] <= 1'b1;
						k_q <= '0;
						state_q <= S_CLEAR;
					end else if (i_q == (SetW+1)'(NumSets-1)) begin
						ovalid_q <= 1'b1; odata_q <= mk(ST_FULL, '0, '0, 1'b0);
						state_q <= S_IDLE;
					end else i_q <= i_q + 1'b1;
				end
				S_CLEAR: begin
					if (k_q == (StgW+1)'(SemsPerSet-1)) begin
						ovalid_q <= 1'b1; odata_q <= mk(ST_OK, req_q.set_id, '0, 1'b0);
						state_q <= S_IDLE;
					end
					k_q <= k_q + 1'b1;
				end
				S_IDXCK: begin
					if (!live_q[st_set_q] || st_bad_q ||
							(k_q != st_cnt_q && {1'b0, kx} >= size_mem[st_set_q])) begin
						ovalid_q <= 1'b1;
						odata_q <= mk(live_q[st_set_q] ? ST_BADARG : ST_NOTFND, '0, '0, 1'b0);
						st_cnt_q <= '0; st_set_q <= '0; st_bad_q <= 1'b0;
						state_q <= S_IDLE;
					end else if (k_q == st_cnt_q) begin
						k_q <= '0; blk_q <= 1'b0; nwf_q <= 1'b0; ovf_q <= 1'b0;
						wvld_q <= '0;
						state_q <= S_CHKRD;
					end else k_q <= k_q + 1'b1;
				end
				S_CHKRD: begin
					if (k_q == st_cnt_q) begin
						st_cnt_q <= '0; st_bad_q <= 1'b0;
						if (blk_q || ovf_q) begin
							ovalid_q <= 1'b1;
							odata_q <= mk(blk_q ? (nwf_q ? ST_NOWAIT : ST_BLOCK) : ST_OVF,
								'0, '0, 1'b0);
							st_set_q <= '0;
							state_q <= S_IDLE;
						end else begin
							k_q <= '0;
							state_q <= S_COMMIT;
						end
					end else state_q <= S_CHKWB;
				end
				S_CHKWB: begin
					if ((st_dlt[kk] < 0 && vsum < 0) || (st_dlt[kk] == 0 && vcur != '0)) begin
						blk_q <= 1'b1;
						if (st_nw[kk]) nwf_q <= 1'b1;
					end else if (vsum > $signed({2'b00, {ValueBits{1'b1}}})) ovf_q <= 1'b1;
					else wvld_q[kx] <= 1'b1;
					k_q <= k_q + 1'b1;
					state_q <= S_CHKRD;
				end
				S_COMMIT: begin
					if (k_q == (StgW+1)'(SemsPerSet-1)) begin
						ovalid_q <= 1'b1; odata_q <= mk(ST_OK, '0, '0, 1'b1);
						st_set_q <= '0;
						state_q <= S_IDLE;
					end
					k_q <= k_q + 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Keyed semaphore set engine testbench
// Drives opens, semop runs, value writes, reads and removals through the
// request channel and checks every response against a behavioral model of
// the set table, with random idling and stalling on both channels.
//------------------------------------------------------------------------------
`default_nettype none
module tb_top;
	import kss_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rsp_t out_data;

	keyed_semaphore_set_engine u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always #5 clk = ~clk;

	// Model state.
	logic        live_q [NumSets];
	logic [30:0] key_q [NumSets];
	logic [4:0]  size_q [NumSets];
	logic [14:0] vals_q [NumSets][SemsPerSet];
	logic [3:0]  stg_ix [StageDepth];
	int          stg_d [StageDepth];
	logic        stg_nw [StageDepth];
	int          stg_cnt;
	logic [3:0]  stg_set;
	logic        stg_bad;

	req_t pending_q[$];
	rsp_t expected_q[$];
	int   errors = 0;
	int   cycles = 0;
	int   send_idle = 0;
	int   recv_stall = 0;
	logic hold = 1'b0;
	logic in_acc = 1'b0;

	function automatic rsp_t mk(status_e st, int rs, int rv, int wk);
		rsp_t r;
		r.status = st;
		r.result_set = 4'(rs);
		r.read_value = 15'(rv);
		r.wake = 1'(wk);
		return r;
	endfunction

	function automatic status_e close_semop();
		int work [SemsPerSet];
		logic blk, nwf, ovf;
		int v;
		blk = 1'b0;
		nwf = 1'b0;
		ovf = 1'b0;
		if (!live_q[stg_set]) return ST_NOTFND;
		if (stg_bad) return ST_BADARG;
		for (int k = 0; k < stg_cnt; k++)
			if (stg_ix[k] >= size_q[stg_set]) return ST_BADARG;
		for (int k = 0; k < SemsPerSet; k++) work[k] = int'(vals_q[stg_set][k]);
		for (int k = 0; k < stg_cnt; k++) begin
			v = work[stg_ix[k]];
			if ((stg_d[k] < 0 && v + stg_d[k] < 0) || (stg_d[k] == 0 && v != 0)) begin
				blk = 1'b1;
				if (stg_nw[k]) nwf = 1'b1;
				continue;
			end
			v += stg_d[k];
			if (v > 32767) begin
				ovf = 1'b1;
				continue;
			end
			work[stg_ix[k]] = v;
		end
		if (blk) return nwf ? ST_NOWAIT : ST_BLOCK;
		if (ovf) return ST_OVF;
		for (int k = 0; k < SemsPerSet; k++) vals_q[stg_set][k] = 15'(work[k]);
		return ST_OK;
	endfunction

	// Applies one accepted request to the model and queues its response.
	function automatic void predict_response(req_t r);
		status_e st;
		int id;
		id = int'(r.set_id);
		case (r.cmd)
			CMD_OPEN: begin
				if (r.sem_count == '0 || r.sem_count > 5'(SemsPerSet)) begin
					expected_q.push_back(mk(ST_BADARG, 0, 0, 0));
					return;
				end
				if (r.set_key != '0)
					for (int i = 0; i < NumSets; i++)
						if (live_q[i] && key_q[i] == r.set_key) begin
							expected_q.push_back(mk(ST_OK, i, 0, 0));
							return;
						end
				if (r.set_key != '0 && !r.create) begin
					expected_q.push_back(mk(ST_NOTFND, 0, 0, 0));
					return;
				end
				for (int i = 0; i < NumSets; i++)
					if (!live_q[i]) begin
						live_q[i] = 1'b1;
						key_q[i] = r.set_key;
						size_q[i] = r.sem_count;
						for (int j = 0; j < SemsPerSet; j++) vals_q[i][j] = '0;
						expected_q.push_back(mk(ST_OK, i, 0, 0));
						return;
					end
				expected_q.push_back(mk(ST_FULL, 0, 0, 0));
			end
			CMD_SEMOP: begin
				if (stg_cnt == 0) begin
					stg_set = r.set_id;
					stg_bad = 1'b0;
				end else if (stg_set != r.set_id) stg_bad = 1'b1;
				if (stg_cnt < StageDepth) begin
					stg_ix[stg_cnt] = r.sem_index;
					stg_d[stg_cnt] = int'(r.op_delta);
					stg_nw[stg_cnt] = r.nowait;
					stg_cnt++;
				end else stg_bad = 1'b1;
				if (r.last) begin
					st = close_semop();
					stg_cnt = 0;
					stg_set = '0;
					stg_bad = 1'b0;
					expected_q.push_back(mk(st, 0, 0, int'(st == ST_OK)));
				end
			end
			CMD_SETVAL, CMD_GETVAL: begin
				if (!live_q[id]) expected_q.push_back(mk(ST_NOTFND, 0, 0, 0));
				else if ({1'b0, r.sem_index} >= size_q[id])
					expected_q.push_back(mk(ST_BADARG, 0, 0, 0));
				else if (r.cmd == CMD_GETVAL)
					expected_q.push_back(mk(ST_OK, 0, int'(vals_q[id][r.sem_index]), 0));
				else begin
					vals_q[id][r.sem_index] = r.new_value;
					expected_q.push_back(mk(ST_OK, 0, 0, 1));
				end
			end
			CMD_REMOVE: begin
				if (!live_q[id]) expected_q.push_back(mk(ST_NOTFND, 0, 0, 0));
				else begin
					live_q[id] = 1'b0;
					expected_q.push_back(mk(ST_OK, 0, 0, 1));
				end
			end
			default: expected_q.push_back(mk(ST_BADARG, 0, 0, 0));
		endcase
	endfunction

	// Request driver.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_acc) begin
				predict_response(in_data);
			end
			if (!in_valid || in_acc) begin
				if (pending_q.size() != 0 && !hold && $urandom_range(99) >= send_idle) begin
					in_data <= pending_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall);
		end
	end

	// Response monitor.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		in_acc <= arst_n && in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				errors <= errors + 1;
				if (errors < 10) $display("unexpected response %p", out_data);
			end else if (out_data !== expected_q[0]) begin
				errors <= errors + 1;
				if (errors < 10)
					$display("expected %p, got %p", expected_q[0], out_data);
				void'(expected_q.pop_front());
			end else begin
				void'(expected_q.pop_front());
			end
		end
		if (cycles > 1500000) begin
			$display("keyed_semaphore_set_engine: mismatch");
			$finish;
		end
	end

	function automatic req_t rand_req();
		req_t r;
		r = '0;
		r.cmd = 3'($urandom_range(7));
		r.set_id = 4'($urandom_range(15));
		r.set_key = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(4));
		r.sem_count = 5'($urandom_range(31));
		r.create = 1'($urandom_range(1));
		r.sem_index = 4'($urandom_range(15));
		r.op_delta = 16'($urandom);
		r.nowait = 1'($urandom_range(1));
		r.new_value = 15'($urandom);
		r.last = 1'($urandom_range(1));
		return r;
	endfunction

	function automatic req_t op_req(cmd_e c, int id, int ix);
		req_t r;
		r = rand_req();
		r.cmd = c;
		r.set_id = 4'(id);
		r.sem_index = 4'(ix);
		return r;
	endfunction

	task automatic push_open(int key, int cnt, logic crt);
		req_t r;
		r = op_req(CMD_OPEN, 0, 0);
		r.set_key = 31'(key);
		r.sem_count = 5'(cnt);
		r.create = crt;
		pending_q.push_back(r);
	endtask

	task automatic push_run(int id, int len, int span);
		req_t r;
		for (int k = 0; k < len; k++) begin
			r = op_req(CMD_SEMOP, id, int'($urandom_range(span)));
			case ($urandom_range(3))
				0: r.op_delta = -16'($urandom_range(3));
				1: r.op_delta = 16'($urandom_range(5));
				2: r.op_delta = '0;
				default: ;
			endcase
			r.last = (k == len - 1);
			pending_q.push_back(r);
		end
	endtask

	task automatic wait_drained();
		while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		req_t r;
		int ph;
		for (int i = 0; i < NumSets; i++) begin
			live_q[i] = 1'b0;
			for (int j = 0; j < SemsPerSet; j++) vals_q[i][j] = '0;
		end
		stg_cnt = 0;
		stg_set = '0;
		stg_bad = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed part.
		push_open(5, 0, 1'b1);
		push_open(5, 17, 1'b1);
		push_open(5, 16, 1'b0);
		push_open(5, 16, 1'b1);
		push_open(0, 1, 1'b0);
		push_open(32'h7FFFFFFF, 4, 1'b1);
		pending_q.push_back(op_req(CMD_GETVAL, 0, 16 - 1));
		r = op_req(CMD_SETVAL, 0, 3);
		r.new_value = 15'h7FFF;
		pending_q.push_back(r);
		r = op_req(CMD_SEMOP, 0, 3);
		r.op_delta = 16'sd1;
		r.last = 1'b1;
		pending_q.push_back(r);
		r.op_delta = -16'sd32768;
		r.nowait = 1'b1;
		pending_q.push_back(r);
		r.op_delta = 16'sd32767;
		r.nowait = 1'b0;
		pending_q.push_back(r);
		r = op_req(CMD_SEMOP, 0, 2);
		r.op_delta = 16'sd2;
		r.last = 1'b0;
		pending_q.push_back(r);
		r.op_delta = -16'sd2;
		r.last = 1'b1;
		pending_q.push_back(r);
		pending_q.push_back(op_req(CMD_GETVAL, 1, 0));
		pending_q.push_back(op_req(CMD_SETVAL, 1, 1));
		pending_q.push_back(op_req(CMD_GETVAL, 9, 0));
		r = op_req(CMD_SEMOP, 0, 0);
		r.last = 1'b0;
		pending_q.push_back(r);
		r.set_id = 4'd1;
		r.last = 1'b1;
		pending_q.push_back(r);
		for (int k = 0; k < 17; k++) begin
			r = op_req(CMD_SEMOP, 0, 0);
			r.op_delta = 16'sd1;
			r.last = (k == 16);
			pending_q.push_back(r);
		end
		pending_q.push_back(op_req(CMD_REMOVE, 2, 0));
		pending_q.push_back(op_req(CMD_REMOVE, 2, 0));
		r = rand_req();
		r.cmd = 3'd7;
		pending_q.push_back(r);
		for (int i = 0; i < 17; i++) push_open(100 + i, 16, 1'b1);
		wait_drained();

		// Random part in idling phases.
		for (ph = 0; ph < 4; ph++) begin
			send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 86 : 26) : 0;
			recv_stall = (ph == 2 || ph == 3) ? ((ph == 2) ? 86 : 26) : 0;
			for (int n = 0; n < 60; n++) begin
				case ($urandom_range(9))
					0: push_open(int'($urandom_range(6)), int'($urandom_range(1, 16)),
						1'($urandom_range(1)));
					1: pending_q.push_back(op_req(CMD_REMOVE, int'($urandom_range(15)), 0));
					2, 3: pending_q.push_back(op_req(CMD_SETVAL, int'($urandom_range(15)),
						int'($urandom_range(15))));
					4: pending_q.push_back(op_req(CMD_GETVAL, int'($urandom_range(15)),
						int'($urandom_range(15))));
					5: pending_q.push_back(rand_req());
					default: push_run(int'($urandom_range(15)), int'($urandom_range(1, 4)),
						int'($urandom_range(15)));
				endcase
			end
			if (ph == 1) begin
				wait_drained();
				hold = 1'b1;
				repeat (40) @(posedge clk);
				hold = 1'b0;
			end
		end
		wait_drained();
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("keyed_semaphore_set_engine: match");
		end else begin
			$display("keyed_semaphore_set_engine: mismatch");
		end
		$finish;
	end
endmodule
`default_nettype wire

### keyed_semaphore_set_engine.f
rtl/kss_pkg.sv
rtl/keyed_semaphore_set_engine.sv
tb/tb_top.sv
